@@ rtl/swca_pkg.sv @@
// ----------------------------------------------------------------------------
// swca_pkg
// Shared constants, beat types and control structs for the sliding-window
// channel averager.
// ----------------------------------------------------------------------------
package swca_pkg;

  localparam int WINDOW_SLOTS = 120;
  localparam int CHANNELS     = 5;

  localparam int SAMPLE_W = 24;
  localparam int MASK_W   = 5;
  localparam int HELD_W   = 7;

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  // count stays below WINDOW_SLOTS: a push into a full window drops the oldest frame
  localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);
  // magnitude of a sum never exceeds WINDOW_SLOTS * 2^(SAMPLE_W-1)
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_SLOTS);
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic                       opcode;
    logic signed [SAMPLE_W-1:0] temperature;
    logic signed [SAMPLE_W-1:0] humidity;
    logic signed [SAMPLE_W-1:0] pressure;
    logic signed [SAMPLE_W-1:0] carbon_dioxide;
    logic signed [SAMPLE_W-1:0] air_quality;
    logic        [MASK_W-1:0]   valid_mask;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg_temperature;
    logic signed [SAMPLE_W-1:0] avg_humidity;
    logic signed [SAMPLE_W-1:0] avg_pressure;
    logic signed [SAMPLE_W-1:0] avg_carbon_dioxide;
    logic signed [SAMPLE_W-1:0] avg_air_quality;
    logic        [HELD_W-1:0]   frames_held;
  } out_item_t;

  typedef struct packed {
    logic clr;        // empty the running sum
    logic push;       // store sample, add to sum
    logic drop;       // subtract the oldest sample read back from the ring
    logic div_start;  // load the divider
    logic div_step;   // one quotient bit
  } lane_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } seq_state_t;

endpackage

@@ rtl/swca_ram.sv @@
// ----------------------------------------------------------------------------
// swca_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module swca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/swca_lane.sv @@
// ----------------------------------------------------------------------------
// swca_lane
// One channel: sample ring, running sum and a bit-serial restoring divider
// that produces sum / count truncated toward zero.
// ----------------------------------------------------------------------------
module swca_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  swca_pkg::lane_ctl_t                  ctl,
  input  logic signed [swca_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 sample_ok,
  input  logic        [swca_pkg::SLOT_W-1:0]   wr_slot,
  input  logic        [swca_pkg::SLOT_W-1:0]   rd_slot,
  input  logic        [swca_pkg::CNT_W-1:0]    count,
  output logic        [swca_pkg::SAMPLE_W-1:0] avg
);

  logic signed [swca_pkg::SAMPLE_W-1:0] smp;
  logic signed [swca_pkg::SAMPLE_W-1:0] old_smp;
  logic signed [swca_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic        [swca_pkg::SUM_W-1:0]    mag_r, mag_nxt;
  logic        [swca_pkg::CNT_W-1:0]    rem_r, rem_nxt;
  logic                                 neg_r, neg_nxt;
  logic        [swca_pkg::CNT_W:0]      rem_sh;
  logic        [swca_pkg::SUM_W-1:0]    quo;

  assign smp = sample_ok ? sample : '0;

  swca_ram #(
    .WIDTH (swca_pkg::SAMPLE_W),
    .DEPTH (swca_pkg::WINDOW_SLOTS)
  ) u_ring (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (wr_slot),
    .wdata (smp),
    .raddr (rd_slot),
    .rdata (old_smp)
  );

  assign rem_sh = {rem_r, mag_r[swca_pkg::SUM_W-1]};

  always_comb begin
    sum_nxt = sum_r;
    mag_nxt = mag_r;
    rem_nxt = rem_r;
    neg_nxt = neg_r;
    if (ctl.clr) begin
      sum_nxt = '0;
    end else if (ctl.push) begin
      sum_nxt = sum_r + {{(swca_pkg::SUM_W-swca_pkg::SAMPLE_W){smp[swca_pkg::SAMPLE_W-1]}}, smp};
    end else if (ctl.drop) begin
      sum_nxt = sum_r -
                {{(swca_pkg::SUM_W-swca_pkg::SAMPLE_W){old_smp[swca_pkg::SAMPLE_W-1]}}, old_smp};
    end
    if (ctl.div_start) begin
      neg_nxt = sum_r[swca_pkg::SUM_W-1];
      mag_nxt = sum_r[swca_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
      rem_nxt = '0;
    end else if (ctl.div_step) begin
      // restoring step: remainder stays below count, so CNT_W bits hold it
      if (rem_sh >= {1'b0, count}) begin
        rem_nxt = swca_pkg::CNT_W'(rem_sh - {1'b0, count});
        mag_nxt = {mag_r[swca_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[swca_pkg::CNT_W-1:0];
        mag_nxt = {mag_r[swca_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign quo = neg_r ? (~mag_r + 1'b1) : mag_r;
  assign avg = quo[swca_pkg::SAMPLE_W-1:0];

endmodule

@@ rtl/swca_merge.sv @@
// ----------------------------------------------------------------------------
// swca_merge
// Collects the lane quotients and the frame count into the result beat and
// holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module swca_merge (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                load,
  input  logic [swca_pkg::CNT_W-1:0]                          count,
  input  logic [swca_pkg::CHANNELS-1:0][swca_pkg::SAMPLE_W-1:0] lane_avg,
  input  logic                                                out_ready,
  output logic                                                out_valid,
  output swca_pkg::out_item_t                                 out_data
);

  logic                                                  out_valid_r, out_valid_nxt;
  swca_pkg::out_item_t                                   out_data_r;
  logic [swca_pkg::CHANNELS-1:0][swca_pkg::SAMPLE_W-1:0] avg_z;

  // empty window: divisor is zero, report zeros
  always_comb begin
    for (int c = 0; c < swca_pkg::CHANNELS; c++) begin
      avg_z[c] = (count == '0) ? '0 : lane_avg[c];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.avg_temperature    <= avg_z[0];
      out_data_r.avg_humidity       <= avg_z[1];
      out_data_r.avg_pressure       <= avg_z[2];
      out_data_r.avg_carbon_dioxide <= avg_z[3];
      out_data_r.avg_air_quality    <= avg_z[4];
      out_data_r.frames_held        <= swca_pkg::HELD_W'(count);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/sliding_window_channel_average.sv @@
// ----------------------------------------------------------------------------
// sliding_window_channel_average
// Windowed per-channel mean of sensor frames: five channel lanes, each with
// its own sample ring, running sum and serial divider, under one sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  in_      in   in_valid / in_ready   in_item_t  (opcode, samples, mask)
//  out_     out  out_valid / out_ready out_item_t (averages, frames_held)
//
//  Push: the accept state, a drop state when the window is full, the divider
//  load, SUM_W (31) divider steps and the emit state. Clear: the accept
//  state, then the emit state.
//  Reset empties the window; the sample rings are not cleared.
//  A new beat is taken while the previous result waits; a finished result
//  waits in the emit state while the output register is still full.
// ----------------------------------------------------------------------------
module sliding_window_channel_average (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swca_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output swca_pkg::out_item_t out_data
);

  swca_pkg::seq_state_t                   state_r, state_nxt;
  logic [swca_pkg::SLOT_W-1:0]            slot_r, slot_nxt, slot_inc;
  logic [swca_pkg::CNT_W-1:0]             count_r, count_nxt, count_inc;
  logic [swca_pkg::STEP_W-1:0]            step_r, step_nxt;
  swca_pkg::lane_ctl_t                    ctl;
  logic                                   in_acc;
  logic                                   merge_load;
  logic                                   merge_free;
  logic signed [swca_pkg::SAMPLE_W-1:0]   smp [swca_pkg::CHANNELS];
  logic [swca_pkg::CHANNELS-1:0][swca_pkg::SAMPLE_W-1:0] lane_avg;

  assign smp[0] = in_data.temperature;
  assign smp[1] = in_data.humidity;
  assign smp[2] = in_data.pressure;
  assign smp[3] = in_data.carbon_dioxide;
  assign smp[4] = in_data.air_quality;

  assign in_ready   = (state_r == swca_pkg::ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign merge_free = !out_valid || out_ready;

  assign slot_inc  = (slot_r == swca_pkg::SLOT_W'(swca_pkg::WINDOW_SLOTS - 1)) ?
                     '0 : slot_r + 1'b1;
  assign count_inc = count_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    ctl           = '0;
    merge_load    = 1'b0;
    unique case (state_r)
      swca_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.opcode == swca_pkg::OP_CLEAR) begin
            ctl.clr   = 1'b1;
            slot_nxt  = '0;
            count_nxt = '0;
            state_nxt = swca_pkg::ST_EMIT;
          end else begin
            ctl.push = 1'b1;
            slot_nxt = slot_inc;
            // full window: oldest frame sits in the slot after the new one
            if (count_inc == swca_pkg::CNT_W'(swca_pkg::WINDOW_SLOTS)) begin
              state_nxt = swca_pkg::ST_DROP;
            end else begin
              count_nxt = count_inc;
              state_nxt = swca_pkg::ST_LOAD;
            end
          end
        end
      end
      swca_pkg::ST_DROP: begin
        ctl.drop  = 1'b1;
        state_nxt = swca_pkg::ST_LOAD;
      end
      swca_pkg::ST_LOAD: begin
        ctl.div_start = 1'b1;
        step_nxt      = '0;
        state_nxt     = swca_pkg::ST_DIV;
      end
      swca_pkg::ST_DIV: begin
        ctl.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == swca_pkg::STEP_W'(swca_pkg::SUM_W - 1)) begin
          state_nxt = swca_pkg::ST_EMIT;
        end
      end
      swca_pkg::ST_EMIT: begin
        if (merge_free) begin
          merge_load = 1'b1;
          state_nxt  = swca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swca_pkg::ST_IDLE;
      slot_r  <= '0;
      count_r <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
    end
  end

  for (genvar c = 0; c < swca_pkg::CHANNELS; c++) begin : g_lane
    swca_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .sample    (smp[c]),
      .sample_ok (in_data.valid_mask[c]),
      .wr_slot   (slot_r),
      .rd_slot   (slot_inc),
      .count     (count_r),
      .avg       (lane_avg[c])
    );
  end

  swca_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (merge_load),
    .count     (count_r),
    .lane_avg  (lane_avg),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // window never holds more than WINDOW_SLOTS-1 frames between beats
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < swca_pkg::CNT_W'(swca_pkg::WINDOW_SLOTS))
    else $error("frame count out of range");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < swca_pkg::SLOT_W'(swca_pkg::WINDOW_SLOTS))
    else $error("write slot out of range");

  a_wrap_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.opcode == swca_pkg::OP_PUSH &&
     count_r == swca_pkg::CNT_W'(swca_pkg::WINDOW_SLOTS - 1))
    |=> (state_r == swca_pkg::ST_DROP))
    else $error("full window push did not drop oldest frame");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.frames_held == '0) |->
    (out_data.avg_temperature == '0 && out_data.avg_humidity == '0 &&
     out_data.avg_pressure == '0 && out_data.avg_carbon_dioxide == '0 &&
     out_data.avg_air_quality == '0))
    else $error("empty window beat carries nonzero average");

endmodule

@@ bench/tb_sliding_window_channel_average.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_channel_average
// Drives frames and clears through the averager with random source gaps and
// sink stalls. A short table of directed beats comes first, then random runs
// whose long ones fill and wrap the window. Each result is compared whole
// against a typed-in beat or a behavioral copy of the window in the bench.
// ----------------------------------------------------------------------------
module tb_sliding_window_channel_average;

  typedef logic signed [swca_pkg::SAMPLE_W-1:0] sample_t;
  typedef logic        [swca_pkg::MASK_W-1:0]   mask_t;

  localparam int      RANDOM_BEATS = 1000;
  localparam int      STALL_LIMIT  = 4000;
  localparam int      DRAIN_CYCLES = 60;
  localparam mask_t   ALL_VALID    = '1;
  localparam sample_t S_MAX        = {1'b0, {(swca_pkg::SAMPLE_W-1){1'b1}}};
  localparam sample_t S_MIN        = {1'b1, {(swca_pkg::SAMPLE_W-1){1'b0}}};

  typedef struct {
    swca_pkg::in_item_t  item;
    bit                  typed;
    swca_pkg::out_item_t want;
  } plan_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  swca_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  swca_pkg::out_item_t out_data;

  // bench copy of the window
  sample_t     ring_mem [swca_pkg::WINDOW_SLOTS][swca_pkg::CHANNELS];
  longint      chan_sum [swca_pkg::CHANNELS];
  int unsigned next_slot;
  int unsigned held;

  swca_pkg::out_item_t mean_q [$];
  plan_row_t           plan [$];

  int  mismatches  = 0;
  int  beats_sent  = 0;
  int  means_seen  = 0;
  int  clears_sent = 0;
  int  wraps       = 0;
  int  idle_cycles = 0;
  int  stall_left  = 0;
  bit  gaps_on     = 1'b1;
  bit  stalls_on   = 1'b1;

  sliding_window_channel_average u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic swca_pkg::out_item_t advance_window(swca_pkg::in_item_t it);
    sample_t             s   [swca_pkg::CHANNELS];
    sample_t             avg [swca_pkg::CHANNELS];
    longint              q;
    swca_pkg::out_item_t r;
    s[0] = it.temperature;
    s[1] = it.humidity;
    s[2] = it.pressure;
    s[3] = it.carbon_dioxide;
    s[4] = it.air_quality;
    if (it.opcode == swca_pkg::OP_CLEAR) begin
      for (int c = 0; c < swca_pkg::CHANNELS; c++) chan_sum[c] = 0;
      next_slot = 0;
      held      = 0;
    end else begin
      for (int c = 0; c < swca_pkg::CHANNELS; c++) begin
        if (!it.valid_mask[c]) s[c] = '0;
        ring_mem[next_slot][c] = s[c];
        chan_sum[c] += longint'(s[c]);
      end
      next_slot = (next_slot + 1 == swca_pkg::WINDOW_SLOTS) ? 0 : next_slot + 1;
      held++;
      // window full: the slot after the one just written holds the oldest frame
      if (held == swca_pkg::WINDOW_SLOTS) begin
        for (int c = 0; c < swca_pkg::CHANNELS; c++)
          chan_sum[c] -= longint'(ring_mem[next_slot][c]);
        held--;
        wraps++;
      end
    end
    for (int c = 0; c < swca_pkg::CHANNELS; c++) begin
      q      = (held == 0) ? 0 : chan_sum[c] / longint'(held);
      avg[c] = q[swca_pkg::SAMPLE_W-1:0];
    end
    r.avg_temperature    = avg[0];
    r.avg_humidity       = avg[1];
    r.avg_pressure       = avg[2];
    r.avg_carbon_dioxide = avg[3];
    r.avg_air_quality    = avg[4];
    r.frames_held        = swca_pkg::HELD_W'(held);
    return r;
  endfunction

  function automatic swca_pkg::in_item_t frame(logic op, sample_t t, sample_t h,
                                               sample_t p, sample_t co, sample_t aq,
                                               mask_t mask);
    swca_pkg::in_item_t it;
    it.opcode         = op;
    it.temperature    = t;
    it.humidity       = h;
    it.pressure       = p;
    it.carbon_dioxide = co;
    it.air_quality    = aq;
    it.valid_mask     = mask;
    return it;
  endfunction

  function automatic swca_pkg::out_item_t means(sample_t t, sample_t h, sample_t p,
                                                sample_t co, sample_t aq, int n);
    swca_pkg::out_item_t r;
    r.avg_temperature    = t;
    r.avg_humidity       = h;
    r.avg_pressure       = p;
    r.avg_carbon_dioxide = co;
    r.avg_air_quality    = aq;
    r.frames_held        = swca_pkg::HELD_W'(n);
    return r;
  endfunction

  task automatic add_row(swca_pkg::in_item_t it, bit typed, swca_pkg::out_item_t want);
    plan_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endtask

  // mostly zero or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 40);
    return $urandom_range(60, 200);
  endfunction

  function automatic sample_t draw_sample(int style);
    case (style)
      1: return S_MAX - swca_pkg::SAMPLE_W'($urandom_range(0, 15));
      2: return S_MIN + swca_pkg::SAMPLE_W'($urandom_range(0, 15));
      3: return swca_pkg::SAMPLE_W'($urandom_range(0, 2000)) - swca_pkg::SAMPLE_W'(1000);
      default: begin
        case ($urandom_range(0, 9))
          0: return S_MAX;
          1: return S_MIN;
          2: return '0;
          3: return swca_pkg::SAMPLE_W'($urandom_range(0, 511)) - swca_pkg::SAMPLE_W'(256);
          default: return swca_pkg::SAMPLE_W'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic send_beat(swca_pkg::in_item_t it, bit typed, swca_pkg::out_item_t want);
    int                  gap;
    swca_pkg::out_item_t predicted;
    gap = gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_window(it);
    mean_q.push_back(typed ? want : predicted);
    beats_sent++;
    if (it.opcode == swca_pkg::OP_CLEAR) clears_sent++;
  endtask

  task automatic drain_means();
    in_valid <= 1'b0;
    do @(posedge clk); while (mean_q.size() != 0);
  endtask

  task automatic send_random(logic op, int style);
    mask_t mask;
    mask = $urandom_range(0, 1) ? ALL_VALID : swca_pkg::MASK_W'($urandom);
    send_beat(frame(op, draw_sample(style), draw_sample(style), draw_sample(style),
                    draw_sample(style), draw_sample(style), mask), 1'b0, '0);
  endtask

  // result sink with random back-pressure
  always @(posedge clk) begin
    if (stall_left == 0 && stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len();
    end
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left  = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    swca_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (mean_q.size() == 0) begin
        flag_error("mean returned with nothing outstanding");
      end else begin
        want = mean_q.pop_front();
        if (out_data !== want)
          flag_error($sformatf("mean %0d: got %h, expected %h", means_seen, out_data, want));
      end
      means_seen++;
    end
  end

  // watchdog: too long without a beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("timeout: no beat in %0d cycles, %0d means outstanding",
               STALL_LIMIT, mean_q.size());
      $display("tb_sliding_window_channel_average failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int seg_len;
    int style;
    int sent;
    bit first_seg;
    for (int c = 0; c < swca_pkg::CHANNELS; c++) chan_sum[c] = 0;
    next_slot = 0;
    held      = 0;

    // directed beats; expected means typed in where obvious
    add_row(frame(swca_pkg::OP_CLEAR, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, ALL_VALID),
            1'b1, '0);
    add_row(frame(swca_pkg::OP_PUSH, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, ALL_VALID), 1'b1,
            means(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 1));
    add_row(frame(swca_pkg::OP_PUSH, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, ALL_VALID),
            1'b0, '0);
    add_row(frame(swca_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0), 1'b1, '0);
    add_row(frame(swca_pkg::OP_PUSH, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, ALL_VALID), 1'b1,
            means(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 1));
    add_row(frame(swca_pkg::OP_PUSH, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, ALL_VALID),
            1'b0, '0);
    add_row(frame(swca_pkg::OP_PUSH, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, ALL_VALID),
            1'b0, '0);
    add_row(frame(swca_pkg::OP_CLEAR, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, ALL_VALID),
            1'b1, '0);
    // invalid channels count as zero
    add_row(frame(swca_pkg::OP_PUSH, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, '0), 1'b1,
            means('0, '0, '0, '0, '0, 1));
    for (int b = 0; b < swca_pkg::MASK_W; b++)
      add_row(frame(swca_pkg::OP_PUSH, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX,
                    swca_pkg::MASK_W'(1) << b), 1'b0, '0);
    add_row(frame(swca_pkg::OP_CLEAR, '0, '0, '0, '0, '0, ALL_VALID), 1'b1, '0);
    add_row(frame(swca_pkg::OP_PUSH, sample_t'(3), sample_t'(-3), sample_t'(1),
                  sample_t'(-1), sample_t'(7), ALL_VALID), 1'b1,
            means(sample_t'(3), sample_t'(-3), sample_t'(1), sample_t'(-1),
                  sample_t'(7), 1));
    // odd sums of mixed sign: quotient must round toward zero
    add_row(frame(swca_pkg::OP_PUSH, sample_t'(-4), sample_t'(4), '0, '0,
                  sample_t'(-8), ALL_VALID), 1'b0, '0);
    add_row(frame(swca_pkg::OP_PUSH, sample_t'(-5), sample_t'(5), sample_t'(-2),
                  sample_t'(2), sample_t'(1), 5'b10101), 1'b0, '0);
    add_row(frame(swca_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0), 1'b1, '0);
    add_row(frame(swca_pkg::OP_CLEAR, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, ALL_VALID),
            1'b1, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_beat(plan[i].item, plan[i].typed, plan[i].want);

    // random runs; long ones fill and wrap the window
    sent      = 0;
    first_seg = 1'b1;
    while (sent < RANDOM_BEATS) begin
      seg_len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                              : $urandom_range(100, 300);
      style     = $urandom_range(0, 3);
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      if (first_seg || $urandom_range(0, 2) == 0) drain_means();
      first_seg = 1'b0;
      send_random(swca_pkg::OP_CLEAR, style);
      sent++;
      for (int i = 0; i < seg_len && sent < RANDOM_BEATS; i++) begin
        send_random(($urandom_range(0, 199) == 0) ? swca_pkg::OP_CLEAR : swca_pkg::OP_PUSH,
                    style);
        sent++;
      end
    end

    drain_means();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d beats sent (%0d clears), %0d means checked, window wrapped %0d times",
             beats_sent, clears_sent, means_seen, wraps);
    if (mismatches == 0) begin
      $display("tb_sliding_window_channel_average passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_sliding_window_channel_average failed");
    end
    $finish;
  end

endmodule
